// ===== rtl/core/spt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg
// shared constants, op codes and controller/datapath handshake structs
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int PERIOD_WIDTH = 16;
    localparam int STEP_WIDTH   = 24;

    localparam int COUNT_W      = STEP_WIDTH + 1;
    localparam int TOGGLE_W     = STEP_WIDTH + 1;
    localparam int SLOT_IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int USED_W       = $clog2(SLOT_COUNT + 1);
    localparam int OP_W         = 2;

    localparam int IN_FIELDS_W  = COUNT_W + PERIOD_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = USED_W + 4;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic do_add;
        logic do_clear;
        logic walk_step;
        logic load_out;
    } spt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bank_empty;
        logic            walk_last;
    } spt_status_t;

endpackage

// ===== rtl/core/spt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_ctrl
// sequencer: takes a word, runs the op, walks slots on a tick, posts result
// ----------------------------------------------------------------------------
module spt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  spt_pkg::spt_status_t stat,
    output spt_pkg::spt_cmd_t    cmd
);
    import spt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (stat.op)
                    OP_TICK:
                    begin
                        if (!stat.bank_empty)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    OP_ADD:   cmd.do_add   = 1'b1;
                    OP_CLEAR: cmd.do_clear = 1'b1;
                    default:  ;
                endcase
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/spt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_datapath
// slot storage, step/direction pins, slot walk and result register
// ----------------------------------------------------------------------------
module spt_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [spt_pkg::OP_W-1:0]         op_in,
    input  logic [spt_pkg::COUNT_W-1:0]      count_in,
    input  logic [spt_pkg::PERIOD_WIDTH-1:0] period_in,
    input  spt_pkg::spt_cmd_t                cmd,
    output spt_pkg::spt_status_t             stat,
    output logic [spt_pkg::OUT_TDATA_W-1:0]  result
);
    import spt_pkg::*;

    // captured item
    logic [OP_W-1:0]         op_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [PERIOD_WIDTH-1:0] period_reg;

    // slot storage, no reset: only slots below used_reg are read
    logic [PERIOD_WIDTH-1:0] period_mem  [SLOT_COUNT];
    logic [PERIOD_WIDTH-1:0] counter_mem [SLOT_COUNT];
    logic [TOGGLE_W-1:0]     toggle_mem  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   enabled_reg;

    logic [USED_W-1:0]       used_reg;
    logic [USED_W-1:0]       used_next;
    logic [SLOT_IDX_W-1:0]   idx_reg;
    logic [SLOT_IDX_W-1:0]   idx_next;
    logic                    pin_reg;
    logic                    pin_next;
    logic                    dir_reg;
    logic                    dir_next;
    logic                    rej_reg;
    logic                    rej_next;
    logic [OUT_TDATA_W-1:0]  result_reg;

    logic                    bank_full;
    logic [SLOT_IDX_W-1:0]   add_idx;
    logic                    count_neg;
    logic [COUNT_W-1:0]      count_mag;
    logic [STEP_WIDTH-1:0]   mag_sat;
    logic [TOGGLE_W-1:0]     add_toggles;
    logic                    add_ok;

    logic [PERIOD_WIDTH-1:0] cur_period;
    logic [PERIOD_WIDTH-1:0] cur_counter;
    logic [TOGGLE_W-1:0]     cur_toggles;
    logic                    cur_enabled;
    logic                    expire;
    logic                    busy;

    // add path: magnitude of the signed count, saturated
    assign bank_full   = (used_reg >= USED_W'(SLOT_COUNT));
    assign add_idx     = used_reg[SLOT_IDX_W-1:0];
    assign count_neg   = count_reg[COUNT_W-1];
    assign count_mag   = count_neg ? (~count_reg + COUNT_W'(1)) : count_reg;
    assign mag_sat     = count_mag[COUNT_W-1] ? {STEP_WIDTH{1'b1}}
                                              : count_mag[STEP_WIDTH-1:0];
    assign add_toggles = {mag_sat, 1'b0};
    assign add_ok      = cmd.do_add && !bank_full;

    // walk path: one slot per cycle
    assign cur_period  = period_mem[idx_reg];
    assign cur_counter = counter_mem[idx_reg];
    assign cur_toggles = toggle_mem[idx_reg];
    assign cur_enabled = enabled_reg[idx_reg];
    assign expire      = cur_enabled && (cur_counter >= cur_period);

    always_comb
    begin
        busy = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (enabled_reg[i] && (USED_W'(i) < used_reg))
            begin
                busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        idx_next  = idx_reg;
        pin_next  = pin_reg;
        dir_next  = dir_reg;
        rej_next  = rej_reg;
        if (cmd.capture)
        begin
            idx_next = '0;
            rej_next = 1'b0;
        end
        if (cmd.do_add)
        begin
            if (bank_full)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                used_next = used_reg + USED_W'(1);
                dir_next  = (!count_neg && (count_reg != '0)) ? 1'b0 : 1'b1;
            end
        end
        if (cmd.do_clear)
        begin
            used_next = '0;
            pin_next  = 1'b0;
        end
        if (cmd.walk_step)
        begin
            idx_next = idx_reg + SLOT_IDX_W'(1);
            if (expire)
            begin
                pin_next = ~pin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            idx_reg  <= '0;
            pin_reg  <= 1'b0;
            dir_reg  <= 1'b0;
            rej_reg  <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            idx_reg  <= idx_next;
            pin_reg  <= pin_next;
            dir_reg  <= dir_next;
            rej_reg  <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_in;
            count_reg  <= count_in;
            period_reg <= period_in;
        end
        if (add_ok)
        begin
            period_mem[add_idx]  <= period_reg;
            counter_mem[add_idx] <= '0;
            toggle_mem[add_idx]  <= add_toggles;
            enabled_reg[add_idx] <= (mag_sat != '0);
        end
        else if (cmd.walk_step && cur_enabled)
        begin
            if (expire)
            begin
                counter_mem[idx_reg] <= '0;
                toggle_mem[idx_reg]  <= cur_toggles - TOGGLE_W'(1);
                if (cur_toggles == TOGGLE_W'(1))
                begin
                    enabled_reg[idx_reg] <= 1'b0;
                end
            end
            else
            begin
                counter_mem[idx_reg] <= cur_counter + PERIOD_WIDTH'(1);
            end
        end
        if (cmd.load_out)
        begin
            result_reg <= OUT_TDATA_W'({rej_reg, busy, used_reg, dir_reg, pin_reg});
        end
    end

    assign stat.op         = op_reg;
    assign stat.bank_empty = (used_reg == '0);
    assign stat.walk_last  = (USED_W'(idx_reg) == (used_reg - USED_W'(1)));
    assign result          = result_reg;

endmodule

// ===== rtl/core/stepper_pulse_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_pulse_timer_bank
// bank of sixteen step-pulse timers sharing one step pin and one direction pin
// ----------------------------------------------------------------------------
// each input word carries an op in tuser: tick walks every used slot in
// order, add appends a slot (period, signed step count), clear empties the
// bank and drives the step pin low; every word yields exactly one result word
// with the pin levels, slot count, busy flag and a reject flag for an add to
// a full bank. a word passes the exec state, then for a tick on a non-empty
// bank the slot walk that reads and updates one slot per cycle, then the done
// state, which loads its result into the output register; only then is the
// next word taken, even if the sink has not yet taken the previous result; a
// result still waiting there holds the following word in its last cycle.
// no clearing pass after reset
// ----------------------------------------------------------------------------
module stepper_pulse_timer_bank (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // signed_steps[24:0], period_ticks[40:25], zero fill above
    input  logic [spt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [spt_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // step_level[0], direction[1], slots_used[6:2], busy_res[7], rejected[8],
    // zero fill above
    output logic [spt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import spt_pkg::*;

    spt_cmd_t    cmd;
    spt_status_t stat;

    // sequencer: one word in flight, walk of used slots on a tick
    spt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // slot storage, pins and the result register
    spt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_in     (s_axis_tuser),
        .count_in  (s_axis_tdata[COUNT_W-1:0]),
        .period_in (s_axis_tdata[IN_FIELDS_W-1:COUNT_W]),
        .cmd       (cmd),
        .stat      (stat),
        .result    (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // result register is only overwritten once the sink has the old word
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");

    // only one word in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    // the slot walk never runs on an empty bank
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> !stat.bank_empty)
        else $error("slot walk on an empty bank");

    // slot count never exceeds the bank size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[USED_W+1:2] <= USED_W'(SLOT_COUNT)))
        else $error("slot count beyond bank size");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stepper pulse timer bank
// ----------------------------------------------------------------------------
// a queue of command words (tick, add slot, bank clear, spare op) is filled
// up front with a short directed opening and then random job sequences.
// a clocked driver plays the queue into the slave port in bursts. each
// accepted word runs through a local model of the slot bank, and the
// predicted pin report goes onto a queue. a clocked monitor takes result
// words from the master port under a changing stall pattern and compares
// them field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;

    import spt_pkg::*;

    // op code the block has no use for, it must only report the current state
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic [COUNT_W:0] MAG_MAX = (COUNT_W + 1)'((1 << STEP_WIDTH) - 1);
    localparam int TARGET_WORDS = 1250;

    // one input word
    typedef struct {
        logic [OP_W-1:0]         op;
        logic [COUNT_W-1:0]      signed_steps;
        logic [PERIOD_WIDTH-1:0] period_ticks;
    } bank_cmd_t;

    // one result word
    typedef struct {
        logic              step_level;
        logic              direction;
        logic [USED_W-1:0] slots_used;
        logic              busy_res;
        logic              rejected;
    } pin_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // signed_steps[24:0], period_ticks[40:25], zero fill above
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // op[1:0]
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // step_level[0], direction[1], slots_used[6:2], busy_res[7], rejected[8],
    // zero fill above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stepper_pulse_timer_bank DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // local copy of the bank
    // ------------------------------------------------------------------------
    logic [PERIOD_WIDTH-1:0] slot_per  [SLOT_COUNT];
    logic [PERIOD_WIDTH-1:0] slot_cnt  [SLOT_COUNT];
    logic [TOGGLE_W-1:0]     slot_left [SLOT_COUNT];
    logic                    slot_on   [SLOT_COUNT];
    logic [USED_W-1:0]       bank_used = '0;
    logic                    bank_pin  = 1'b0;
    logic                    bank_dir  = 1'b0;

    bank_cmd_t   cmd_q [$];          // words waiting to be driven
    pin_report_t pin_reports_q [$];  // predicted reports, oldest first

    int n_ticks, n_adds, n_refused, n_clears, n_spare;
    int words_checked, mismatch_cnt, words_queued;

    // applies one accepted word to the local bank, returns the pin report
    function automatic pin_report_t predict_pins(input bank_cmd_t cmd);
        pin_report_t           r;
        logic                  neg;
        logic [COUNT_W:0]      mag;
        logic [SLOT_IDX_W-1:0] s;
        int                    i;
        r = '{default: 1'b0};
        if (cmd.op == OP_TICK)
        begin
            n_ticks++;
            // slots walk in ascending order, each expiry flips the shared pin
            for (i = 0; i < bank_used; i++)
            begin
                if (slot_on[i])
                begin
                    if (slot_cnt[i] >= slot_per[i])
                    begin
                        bank_pin    = ~bank_pin;
                        slot_cnt[i] = '0;
                        if (slot_left[i] != 0)
                            slot_left[i] = slot_left[i] - 1'b1;
                        if (slot_left[i] == 0)
                            slot_on[i] = 1'b0;
                    end
                    else
                    begin
                        slot_cnt[i] = slot_cnt[i] + 1'b1;
                    end
                end
            end
        end
        else if (cmd.op == OP_ADD)
        begin
            n_adds++;
            if (bank_used >= SLOT_COUNT)
            begin
                // full bank: nothing changes, only the flag
                r.rejected = 1'b1;
                n_refused++;
            end
            else
            begin
                neg = cmd.signed_steps[COUNT_W-1];
                mag = neg ? ({1'b1, {COUNT_W{1'b0}}} - {1'b0, cmd.signed_steps})
                          : {1'b0, cmd.signed_steps};
                // most negative count saturates
                if (mag > MAG_MAX)
                    mag = MAG_MAX;
                // zero counts as not positive
                bank_dir = (!neg && cmd.signed_steps != 0) ? 1'b0 : 1'b1;
                s            = bank_used[SLOT_IDX_W-1:0];
                slot_per[s]  = cmd.period_ticks;
                slot_cnt[s]  = '0;
                slot_left[s] = {mag[COUNT_W-2:0], 1'b0};
                slot_on[s]   = (mag != 0);
                bank_used    = bank_used + 1'b1;
            end
        end
        else if (cmd.op == OP_CLEAR)
        begin
            n_clears++;
            // direction pin keeps its level
            bank_used = '0;
            bank_pin  = 1'b0;
        end
        else
        begin
            n_spare++;
        end
        for (i = 0; i < bank_used; i++)
            if (slot_on[i])
                r.busy_res = 1'b1;
        r.step_level = bank_pin;
        r.direction  = bank_dir;
        r.slots_used = bank_used;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [OP_W-1:0] op, input int count, input int period);
        bank_cmd_t c;
        c.op           = op;
        c.signed_steps = COUNT_W'(count);
        c.period_ticks = PERIOD_WIDTH'(period);
        cmd_q.push_back(c);
        if (op != OP_SPARE)
            words_queued++;
    endtask

    // mostly short jobs so slots finish, now and then a long or odd one
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 6) - 3;
        else if (r < 9)
            return $urandom_range(0, 40) - 20;
        return $urandom;
    endfunction

    function automatic int pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 3);
        else if (r < 9)
            return $urandom_range(0, 20);
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    bank_cmd_t cur_cmd;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pin_reports_q.push_back(predict_pins(cur_cmd));
            // a word on offer is held until taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_q.size() != 0)
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_axis_tdata  <= IN_TDATA_W'({cur_cmd.period_ticks, cur_cmd.signed_steps});
                    s_axis_tuser  <= cur_cmd.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // about a third of the bursts follow on with no gap
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall pattern: stretches of always ready, coin flip, or long
    // stalls with rare ready cycles
    // ------------------------------------------------------------------------
    int rx_mode = 0;
    int rx_span = 0;

    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(20, 200);
        end
        else
        begin
            rx_span--;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // monitor: every result word against the oldest prediction
    // ------------------------------------------------------------------------
    pin_report_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pin_reports_q.size() == 0)
            begin
                $error("result word %h with no prediction waiting", m_axis_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = pin_reports_q.pop_front();
                words_checked++;
                if (m_axis_tdata[0] !== want.step_level)
                begin
                    $error("step_level: expected %0d, got %0d", want.step_level,
                           m_axis_tdata[0]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[1] !== want.direction)
                begin
                    $error("direction: expected %0d, got %0d", want.direction,
                           m_axis_tdata[1]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[USED_W+1:2] !== want.slots_used)
                begin
                    $error("slots_used: expected %0d, got %0d", want.slots_used,
                           m_axis_tdata[USED_W+1:2]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[USED_W+2] !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res,
                           m_axis_tdata[USED_W+2]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[USED_W+3] !== want.rejected)
                begin
                    $error("rejected: expected %0d, got %0d", want.rejected,
                           m_axis_tdata[USED_W+3]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int pick;
        int i;

        // directed opening
        queue_cmd(OP_TICK, 0, 0);                    // tick on an empty bank
        queue_cmd(OP_ADD, 0, 0);                     // zero count: parked slot, dir 1
        queue_cmd(OP_ADD, 1, 0);                     // positive count: dir 0
        queue_cmd(OP_ADD, -2, 1);                    // negative count: magnitude used
        queue_cmd(OP_ADD, 16777215, 65535);          // largest count and period
        queue_cmd(OP_ADD, -16777216, 0);             // most negative count saturates
        queue_cmd(OP_ADD, -16777215, 65535);
        for (i = 6; i < SLOT_COUNT; i++)
            queue_cmd(OP_ADD, (i % 2) ? -1 : 1, i % 3);
        queue_cmd(OP_ADD, 5, 7);                     // bank full: refused
        repeat (3)
            queue_cmd(OP_TICK, 0, 0);                // several slots expire per tick
        queue_cmd(OP_SPARE, 0, 0);                   // spare op only reports state
        queue_cmd(OP_CLEAR, 0, 0);                   // clear keeps the direction pin
        queue_cmd(OP_TICK, 0, 0);

        // random part: mostly well-formed jobs, some bank fills, some noise
        while (words_queued < TARGET_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                // short job: a clear most of the time, a few slots, then ticks to run them down
                if ($urandom_range(0, 4) != 0)
                    queue_cmd(OP_CLEAR, $urandom, $urandom);
                repeat ($urandom_range(1, 5))
                    queue_cmd(OP_ADD, pick_count(), pick_period());
                repeat ($urandom_range(4, 40))
                    queue_cmd(OP_TICK, $urandom, $urandom);
            end
            else if (pick < 8)
            begin
                // fill the bank and often push past it
                queue_cmd(OP_CLEAR, $urandom, $urandom);
                repeat ($urandom_range(SLOT_COUNT, SLOT_COUNT + 3))
                    queue_cmd(OP_ADD, pick_count(), pick_period());
                repeat ($urandom_range(10, 40))
                    queue_cmd(OP_TICK, $urandom, $urandom);
            end
            else
            begin
                // noise: any op, any field bits
                repeat ($urandom_range(3, 12))
                begin
                    i = $urandom_range(0, 15);
                    queue_cmd((i < 6) ? OP_TICK : (i < 11) ? OP_ADD :
                              (i < 14) ? OP_CLEAR : OP_SPARE, $urandom, $urandom);
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // every word taken, then every prediction compared, then a quiet tail
        // longer than the slowest tick walk to catch stray result words
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pin_reports_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d ticks, %0d adds (%0d refused on a full bank), %0d clears, %0d spare ops",
                 n_ticks, n_adds, n_refused, n_clears, n_spare);
        $display("%0d result words compared, %0d field errors", words_checked, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d words still to send, %0d predictions waiting",
                 cmd_q.size(), pin_reports_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
